>>> design/tcpop_pkg.sv
`default_nettype none
package tcpop_pkg;

    // option kinds below this limit get a bit in the seen mask and may not repeat
    localparam int FLAG_LIMIT      = 16;
    localparam int MAX_SACK_BLOCKS = 4;
    localparam int STORE_DEPTH     = 4;
    localparam int SACK_BLK_W      = 64;
    localparam int MASK_LIMIT      = (FLAG_LIMIT < 16) ? FLAG_LIMIT : 16;
    localparam int SACK_CAP_RAW    = (MAX_SACK_BLOCKS < STORE_DEPTH) ? MAX_SACK_BLOCKS
                                                                     : STORE_DEPTH;
    localparam int SACK_CAP        = (SACK_CAP_RAW < 1) ? 1 : SACK_CAP_RAW;

    localparam logic [7:0] KIND_EOL     = 8'd0;
    localparam logic [7:0] KIND_NOP     = 8'd1;
    localparam logic [7:0] KIND_MSS     = 8'd2;
    localparam logic [7:0] KIND_WSCALE  = 8'd3;
    localparam logic [7:0] KIND_SACK_OK = 8'd4;
    localparam logic [7:0] KIND_SACK    = 8'd5;
    localparam logic [7:0] KIND_TS      = 8'd8;
    localparam logic [7:0] MIN_OPT_LEN  = 8'd2;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_SHORT_LEN = 2'd1,
        ST_BAD_SACK  = 2'd2,
        ST_BAD_TS    = 2'd3
    } t_status;

    typedef struct packed {
        logic [7:0] opt_byte;
        logic       last;
        logic       no_bytes;
    } t_in_item;

    typedef struct packed {
        logic [15:0] mss;
        logic [7:0]  wscale;
        logic        sack_ok;
        logic [31:0] ts_val;
        logic [31:0] ts_ecr;
        logic [2:0]  sack_count;
        logic [1:0]  sack_index;
        logic [31:0] sack_begin;
        logic [31:0] sack_end;
        logic [1:0]  status;
        logic [15:0] seen_mask;
        logic        end_of_run;
    } t_out_item;

    // everything gathered for one segment, handed from parser to result stage
    typedef struct packed {
        logic [15:0]                                mss;
        logic [7:0]                                 wscale;
        logic                                       sack_ok;
        logic [31:0]                                ts_val;
        logic [31:0]                                ts_ecr;
        logic [2:0]                                 sack_num;
        t_status                                    status;
        logic [15:0]                                seen;
        logic [STORE_DEPTH-1:0][SACK_BLK_W-1:0]     sack_blk;
    } t_snap;

endpackage
`default_nettype wire

>>> design/tcp_option_parser.sv
// tcp option parser
// input channel (i_in_valid / o_in_ready / i_in_data) carries the options area
// of a segment one byte per word; last marks the final byte, no_bytes marks a
// segment whose options area is empty (its byte is ignored)
// output channel (o_out_valid / i_out_ready / o_out_data) gives, for each
// segment, one word per stored sack block, or a single word when there is
// none; end_of_run marks the final word of the segment
// the first word of a segment appears in the cycle after its final byte is taken
// throughput: one byte per cycle; the parser state is updated in a single
// pass per byte. the result stage holds one segment, so after a segment with
// n sack blocks only the final byte (or an empty-area word) of the next
// segment waits until the last word has been taken; earlier bytes flow on
// a stalled receiver holds the current word and, once the result stage is
// full, holds off the next segment's final word as well
// reset (synchronous, active low) returns the parser to the start of a
// segment with all but the sack blocks cleared and empties the result stage
`default_nettype none
module tcp_option_parser (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    output logic                 o_in_ready,
    input  tcpop_pkg::t_in_item  i_in_data,
    output logic                 o_out_valid,
    input  wire                  i_out_ready,
    output tcpop_pkg::t_out_item o_out_data
);
    import tcpop_pkg::*;

    logic  can_load;
    logic  take;
    logic  load;
    t_snap snap;

    // only a word that closes a segment needs room in the result stage
    assign o_in_ready = can_load | ~(i_in_data.last | i_in_data.no_bytes);
    assign take       = i_in_valid & o_in_ready;

    tcpop_parse u_parse (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_data  (i_in_data),
        .o_load  (load),
        .o_snap  (snap)
    );

    tcpop_emit u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (load),
        .i_snap      (snap),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .o_can_load  (can_load)
    );

endmodule
`default_nettype wire

>>> design/tcpop_parse.sv
`default_nettype none
module tcpop_parse (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_take,
    input  tcpop_pkg::t_in_item i_data,
    output logic                o_load,
    output tcpop_pkg::t_snap    o_snap
);
    import tcpop_pkg::*;

    typedef enum logic [3:0] {
        PH_KIND = 4'b0001,
        PH_LEN  = 4'b0010,
        PH_BODY = 4'b0100,
        PH_DONE = 4'b1000
    } t_phase;

    function automatic logic kind_flag(input logic [7:0] k);
        return {1'b0, k} < 9'(MASK_LIMIT);
    endfunction

    t_phase      r_phase, n_phase;
    logic [7:0]  r_kind, n_kind;
    logic [7:0]  r_left, n_left;
    logic [7:0]  r_pos, n_pos;
    logic [15:0] r_mss, n_mss;
    logic [7:0]  r_wscale, n_wscale;
    logic        r_sack_ok, n_sack_ok;
    logic [31:0] r_ts_val, n_ts_val;
    logic [31:0] r_ts_ecr, n_ts_ecr;
    logic [2:0]  r_num, n_num;
    logic [15:0] r_seen, n_seen;
    t_status     r_status, n_status;
    logic [STORE_DEPTH-1:0][SACK_BLK_W-1:0] r_sack, n_sack;

    logic [7:0] b;
    logic [7:0] len_n;
    logic [4:0] sack_cnt;
    logic [4:0] blk;
    logic [2:0] lane;
    logic       fin;

    assign b        = i_data.opt_byte;
    assign len_n    = b - MIN_OPT_LEN;
    assign sack_cnt = len_n[7:3];
    assign blk      = r_pos[7:3];
    assign lane     = r_pos[2:0];
    assign fin      = i_data.last | i_data.no_bytes;

    always_comb begin
        n_phase   = r_phase;
        n_kind    = r_kind;
        n_left    = r_left;
        n_pos     = r_pos;
        n_mss     = r_mss;
        n_wscale  = r_wscale;
        n_sack_ok = r_sack_ok;
        n_ts_val  = r_ts_val;
        n_ts_ecr  = r_ts_ecr;
        n_num     = r_num;
        n_seen    = r_seen;
        n_status  = r_status;
        n_sack    = r_sack;
        unique case (r_phase)
            PH_KIND: begin
                priority if (b == KIND_EOL) begin
                    n_phase = PH_DONE;
                end else if (b == KIND_NOP) begin
                    n_phase = PH_KIND;
                end else if (kind_flag(b) && r_seen[b[3:0]]) begin
                    // repeated option: stop quietly
                    n_phase = PH_DONE;
                end else begin
                    n_kind  = b;
                    n_phase = PH_LEN;
                end
            end
            PH_LEN: begin
                priority if (b < MIN_OPT_LEN) begin
                    n_status = ST_SHORT_LEN;
                    n_phase  = PH_DONE;
                end else if (r_kind == KIND_SACK && len_n[2:0] != 3'd0) begin
                    n_status = ST_BAD_SACK;
                    n_phase  = PH_DONE;
                end else if (r_kind == KIND_TS && len_n[1:0] != 2'd0) begin
                    n_status = ST_BAD_TS;
                    n_phase  = PH_DONE;
                end else begin
                    unique case (r_kind)
                        KIND_MSS:     n_mss = '0;
                        KIND_WSCALE:  n_wscale = '0;
                        KIND_SACK_OK: n_sack_ok = 1'b1;
                        KIND_SACK: begin
                            n_num  = (sack_cnt > 5'(SACK_CAP)) ? 3'(SACK_CAP) : sack_cnt[2:0];
                            n_sack = '0;
                        end
                        KIND_TS: begin
                            n_ts_val = '0;
                            n_ts_ecr = '0;
                        end
                        default: ;
                    endcase
                    if (kind_flag(r_kind)) begin
                        n_seen[r_kind[3:0]] = 1'b1;
                    end
                    n_left  = len_n;
                    n_pos   = '0;
                    n_phase = (len_n != 8'd0) ? PH_BODY : PH_KIND;
                end
            end
            PH_BODY: begin
                unique case (r_kind)
                    KIND_MSS: begin
                        if (r_pos == 8'd0) begin
                            n_mss[15:8] = r_mss[15:8] | b;
                        end else if (r_pos == 8'd1) begin
                            n_mss[7:0] = r_mss[7:0] | b;
                        end
                    end
                    KIND_WSCALE: begin
                        if (r_pos == 8'd0) begin
                            n_wscale = b;
                        end
                    end
                    KIND_SACK: begin
                        // blocks big-endian, first byte in the top lane
                        if (blk < {2'b00, r_num} && blk < 5'(STORE_DEPTH)) begin
                            n_sack[blk[1:0]][{~lane, 3'b000} +: 8] =
                                r_sack[blk[1:0]][{~lane, 3'b000} +: 8] | b;
                        end
                    end
                    KIND_TS: begin
                        if (r_pos < 8'd4) begin
                            n_ts_val[{~r_pos[1:0], 3'b000} +: 8] =
                                r_ts_val[{~r_pos[1:0], 3'b000} +: 8] | b;
                        end else if (r_pos < 8'd8) begin
                            n_ts_ecr[{~r_pos[1:0], 3'b000} +: 8] =
                                r_ts_ecr[{~r_pos[1:0], 3'b000} +: 8] | b;
                        end
                    end
                    default: ;
                endcase
                n_pos  = r_pos + 8'd1;
                n_left = r_left - 8'd1;
                if (r_left == 8'd1) begin
                    n_phase = PH_KIND;
                end
            end
            PH_DONE: ;
            default: n_phase = PH_DONE;
        endcase
    end

    // snapshot for the result stage; a missing length byte reads as zero
    always_comb begin
        o_load = i_take & fin;
        o_snap = '0;
        if (!i_data.no_bytes) begin
            o_snap.mss      = n_mss;
            o_snap.wscale   = n_wscale;
            o_snap.sack_ok  = n_sack_ok;
            o_snap.ts_val   = n_ts_val;
            o_snap.ts_ecr   = n_ts_ecr;
            o_snap.sack_num = n_num;
            o_snap.status   = (n_phase == PH_LEN) ? ST_SHORT_LEN : n_status;
            o_snap.seen     = n_seen;
            o_snap.sack_blk = n_sack;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_take && fin)) begin
            r_phase   <= PH_KIND;
            r_kind    <= '0;
            r_left    <= '0;
            r_pos     <= '0;
            r_mss     <= '0;
            r_wscale  <= '0;
            r_sack_ok <= 1'b0;
            r_ts_val  <= '0;
            r_ts_ecr  <= '0;
            r_num     <= '0;
            r_seen    <= '0;
            r_status  <= ST_OK;
        end else if (i_take) begin
            r_phase   <= n_phase;
            r_kind    <= n_kind;
            r_left    <= n_left;
            r_pos     <= n_pos;
            r_mss     <= n_mss;
            r_wscale  <= n_wscale;
            r_sack_ok <= n_sack_ok;
            r_ts_val  <= n_ts_val;
            r_ts_ecr  <= n_ts_ecr;
            r_num     <= n_num;
            r_seen    <= n_seen;
            r_status  <= n_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take) begin
            r_sack <= n_sack;
        end
    end

endmodule
`default_nettype wire

>>> design/tcpop_emit.sv
`default_nettype none
module tcpop_emit (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_load,
    input  tcpop_pkg::t_snap     i_snap,
    input  wire                  i_out_ready,
    output logic                 o_out_valid,
    output tcpop_pkg::t_out_item o_out_data,
    output logic                 o_can_load
);
    import tcpop_pkg::*;

    logic       r_valid;
    t_snap      r_snap;
    logic [1:0] r_idx;
    logic       last_res;
    logic       out_take;
    logic [SACK_BLK_W-1:0] blk_sel;

    assign last_res   = (r_snap.sack_num == 3'd0) || ({1'b0, r_idx} == r_snap.sack_num - 3'd1);
    assign out_take   = r_valid & i_out_ready;
    // a new snapshot may land as the final word of the current one leaves
    assign o_can_load = ~r_valid | (out_take & last_res);
    assign blk_sel    = r_snap.sack_blk[r_idx];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (i_load) begin
            r_valid <= 1'b1;
            r_idx   <= '0;
        end else if (out_take) begin
            if (last_res) begin
                r_valid <= 1'b0;
            end else begin
                r_idx <= r_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_snap <= i_snap;
        end
    end

    always_comb begin
        o_out_valid           = r_valid;
        o_out_data.mss        = r_snap.mss;
        o_out_data.wscale     = r_snap.wscale;
        o_out_data.sack_ok    = r_snap.sack_ok;
        o_out_data.ts_val     = r_snap.ts_val;
        o_out_data.ts_ecr     = r_snap.ts_ecr;
        o_out_data.sack_count = r_snap.sack_num;
        o_out_data.sack_index = r_idx;
        o_out_data.status     = r_snap.status;
        o_out_data.seen_mask  = r_snap.seen;
        o_out_data.end_of_run = last_res;
        if (r_snap.sack_num == 3'd0) begin
            o_out_data.sack_begin = '0;
            o_out_data.sack_end   = '0;
        end else begin
            o_out_data.sack_begin = blk_sel[63:32];
            o_out_data.sack_end   = blk_sel[31:0];
        end
    end

endmodule
`default_nettype wire

>>> design/tcpop_checker.sv
`default_nettype none
module tcpop_checker (
    input wire                  i_clk,
    input wire                  i_rst_n,
    input wire                  o_out_valid,
    input wire                  i_out_ready,
    input tcpop_pkg::t_out_item o_out_data
);
    import tcpop_pkg::*;

    // nothing to show straight after reset
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("result word present after reset");

    // stalled word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result word changed");

    // block index stays below the block count
    a_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.sack_count != 3'd0
            |-> {1'b0, o_out_data.sack_index} < o_out_data.sack_count)
        else $error("sack index beyond block count");

    // no blocks: a single zero-edged word closes the segment
    a_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.sack_count == 3'd0
            |-> o_out_data.end_of_run && o_out_data.sack_index == 2'd0
                && o_out_data.sack_begin == 32'd0 && o_out_data.sack_end == 32'd0)
        else $error("blockless segment word malformed");

    // words of one segment step through the blocks in order
    a_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && !o_out_data.end_of_run
            |=> o_out_valid && o_out_data.sack_index == $past(o_out_data.sack_index) + 2'd1)
        else $error("sack words out of order");

endmodule

bind tcp_option_parser tcpop_checker u_tcpop_checker (.*);
`default_nettype wire

>>> dv/tcp_option_parser_test.sv
`timescale 1ns / 100ps
module tcp_option_parser_test;
    import tcpop_pkg::*;

    localparam int RANDOM_ITEMS   = 360;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int IDLE_PCT       = 19;

    typedef logic [7:0] t_bytes[$];
    typedef enum logic [1:0] {PH_KIND, PH_LEN, PH_BODY, PH_DONE} t_parse_phase;

    class option_scoreboard;
        t_parse_phase phase;
        logic [7:0]   kind_q;
        int           body_left;
        int           body_pos;
        logic [15:0]  mss_v;
        logic [7:0]   wscale_v;
        logic         sack_ok_v;
        logic [31:0]  ts_val_v;
        logic [31:0]  ts_ecr_v;
        logic [63:0]  sack_blk [STORE_DEPTH];
        int           sack_num;
        logic [15:0]  seen_v;
        t_status      status_v;
        t_out_item    expected_q[$];
        int           errors;

        function new();
            foreach (sack_blk[i]) sack_blk[i] = '0;
            errors = 0;
            clear_segment();
        endfunction

        function void clear_segment();
            phase     = PH_KIND;
            kind_q    = '0;
            body_left = 0;
            body_pos  = 0;
            mss_v     = '0;
            wscale_v  = '0;
            sack_ok_v = 1'b0;
            ts_val_v  = '0;
            ts_ecr_v  = '0;
            sack_num  = 0;
            seen_v    = '0;
            status_v  = ST_OK;
        endfunction

        function bit flagged(logic [7:0] k);
            return (k < FLAG_LIMIT) && (k < 16);
        endfunction

        function void take_kind(logic [7:0] b);
            if (b == KIND_EOL) begin
                phase = PH_DONE;
            end else if (b == KIND_NOP) begin
                phase = PH_KIND;
            end else if (flagged(b) && seen_v[b[3:0]]) begin
                // repeated option ends the parse quietly
                phase = PH_DONE;
            end else begin
                kind_q = b;
                phase  = PH_LEN;
            end
        endfunction

        function void take_len(logic [7:0] b);
            int n;
            int cnt;
            if (b < MIN_OPT_LEN) begin
                status_v = ST_SHORT_LEN;
                phase    = PH_DONE;
                return;
            end
            n = int'(b) - 2;
            case (kind_q)
                KIND_MSS:     mss_v = '0;
                KIND_WSCALE:  wscale_v = '0;
                KIND_SACK_OK: sack_ok_v = 1'b1;
                KIND_SACK: begin
                    if (n % 8 != 0) begin
                        status_v = ST_BAD_SACK;
                        phase    = PH_DONE;
                        return;
                    end
                    cnt = n / 8;
                    if (cnt > SACK_CAP) cnt = SACK_CAP;
                    sack_num = cnt;
                    for (int i = 0; i < cnt; i++) sack_blk[i] = '0;
                end
                KIND_TS: begin
                    if (n % 4 != 0) begin
                        status_v = ST_BAD_TS;
                        phase    = PH_DONE;
                        return;
                    end
                    ts_val_v = '0;
                    ts_ecr_v = '0;
                end
                default: ;
            endcase
            if (flagged(kind_q)) seen_v[kind_q[3:0]] = 1'b1;
            body_left = n;
            body_pos  = 0;
            phase     = (n != 0) ? PH_BODY : PH_KIND;
        endfunction

        function void take_body(logic [7:0] b);
            int p;
            int blk;
            p = body_pos;
            case (kind_q)
                KIND_MSS: begin
                    if (p == 0) mss_v = mss_v | (16'(b) << 8);
                    else if (p == 1) mss_v = mss_v | 16'(b);
                end
                KIND_WSCALE: begin
                    if (p == 0) wscale_v = b;
                end
                KIND_SACK: begin
                    blk = p >> 3;
                    if (blk < sack_num && blk < STORE_DEPTH)
                        sack_blk[blk] = sack_blk[blk] | (64'(b) << ((7 - (p & 7)) * 8));
                end
                KIND_TS: begin
                    if (p < 4) ts_val_v = ts_val_v | (32'(b) << ((3 - p) * 8));
                    else if (p < 8) ts_ecr_v = ts_ecr_v | (32'(b) << ((7 - p) * 8));
                end
                default: ;
            endcase
            body_pos++;
            body_left--;
            if (body_left == 0) phase = PH_KIND;
        endfunction

        function void emit_segment();
            t_out_item w;
            int n;
            n = (sack_num > STORE_DEPTH) ? STORE_DEPTH : sack_num;
            w.mss        = mss_v;
            w.wscale     = wscale_v;
            w.sack_ok    = sack_ok_v;
            w.ts_val     = ts_val_v;
            w.ts_ecr     = ts_ecr_v;
            w.sack_count = 3'(sack_num);
            w.status     = status_v;
            w.seen_mask  = seen_v;
            if (n == 0) begin
                w.sack_index = '0;
                w.sack_begin = '0;
                w.sack_end   = '0;
                w.end_of_run = 1'b1;
                expected_q.push_back(w);
            end else begin
                for (int k = 0; k < n; k++) begin
                    w.sack_index = 2'(k);
                    w.sack_begin = sack_blk[k][63:32];
                    w.sack_end   = sack_blk[k][31:0];
                    w.end_of_run = (k == n - 1);
                    expected_q.push_back(w);
                end
            end
        endfunction

        function void note_input(t_in_item w);
            if (w.no_bytes) begin
                // empty options area throws away any partial segment
                clear_segment();
                emit_segment();
                clear_segment();
                return;
            end
            case (phase)
                PH_KIND: take_kind(w.opt_byte);
                PH_LEN:  take_len(w.opt_byte);
                PH_BODY: take_body(w.opt_byte);
                default: ;
            endcase
            if (!w.last) return;
            if (phase == PH_LEN) take_len(8'd0);
            emit_segment();
            clear_segment();
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        task report_mismatch(string msg);
            $display("ERROR at %0t: %s", $realtime, msg);
            errors++;
        endtask

        task cmp(string field, logic [31:0] got_v, logic [31:0] exp_v);
            if (got_v !== exp_v)
                report_mismatch($sformatf("%s got %0h expected %0h", field, got_v, exp_v));
        endtask

        task check_word(t_out_item got);
            t_out_item exp_w;
            if (expected_q.size() == 0) begin
                report_mismatch($sformatf("unexpected result word %0h", got));
                return;
            end
            exp_w = expected_q.pop_front();
            cmp("mss", got.mss, exp_w.mss);
            cmp("wscale", got.wscale, exp_w.wscale);
            cmp("sack_ok", got.sack_ok, exp_w.sack_ok);
            cmp("ts_val", got.ts_val, exp_w.ts_val);
            cmp("ts_ecr", got.ts_ecr, exp_w.ts_ecr);
            cmp("sack_count", got.sack_count, exp_w.sack_count);
            cmp("sack_index", got.sack_index, exp_w.sack_index);
            cmp("sack_begin", got.sack_begin, exp_w.sack_begin);
            cmp("sack_end", got.sack_end, exp_w.sack_end);
            cmp("status", got.status, exp_w.status);
            cmp("seen_mask", got.seen_mask, exp_w.seen_mask);
            cmp("end_of_run", got.end_of_run, exp_w.end_of_run);
        endtask

        task leftover_check();
            if (expected_q.size() != 0)
                report_mismatch($sformatf("%0d result words never arrived", expected_q.size()));
        endtask
    endclass

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    t_in_item  in_data   = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_item out_data;

    option_scoreboard sb;
    int items_sent   = 0;
    int in_idle_pct  = IDLE_PCT;
    bit calm         = 1'b0;
    int quiet_cycles = 0;

    tcp_option_parser u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk) begin
        out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end

    // words are taken at the edge from the values settled before it
    always @(posedge clk) begin
        if (rst_n) begin
            if (in_valid && in_ready) sb.note_input(in_data);
            if (out_valid && out_ready) sb.check_word(out_data);
            if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
            else quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    task automatic put_word(t_in_item w);
        while ($urandom_range(99) < in_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        items_sent++;
    endtask

    task automatic send_bytes(t_bytes q, bit mark_last);
        t_in_item w;
        for (int i = 0; i < q.size(); i++) begin
            w.opt_byte = q[i];
            w.last     = mark_last && (i == q.size() - 1);
            w.no_bytes = 1'b0;
            put_word(w);
        end
    endtask

    task automatic send_empty();
        t_in_item w;
        w.opt_byte = 8'($urandom_range(255));
        w.last     = 1'($urandom_range(1));
        w.no_bytes = 1'b1;
        put_word(w);
    endtask

    // hold the sender off until every expected word has been taken
    task automatic drain_results();
        in_valid <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
    endtask

    function automatic void add_random(ref t_bytes q, input int n);
        for (int i = 0; i < n; i++) q.push_back(8'($urandom_range(255)));
    endfunction

    function automatic void add_option(ref t_bytes q);
        int r;
        int nb;
        int len;
        logic [7:0] k;
        case ($urandom_range(7))
            0: begin
                q.push_back(KIND_MSS); q.push_back(8'd4); add_random(q, 2);
            end
            1: begin
                q.push_back(KIND_WSCALE); q.push_back(8'd3); add_random(q, 1);
            end
            2: begin
                q.push_back(KIND_SACK_OK); q.push_back(8'd2);
            end
            3: begin
                r  = $urandom_range(9);
                nb = (r < 1) ? 0 : (r < 8) ? $urandom_range(1, 4) : 5;
                q.push_back(KIND_SACK); q.push_back(8'(2 + 8 * nb)); add_random(q, 8 * nb);
            end
            4: begin
                q.push_back(KIND_TS); q.push_back(8'd10); add_random(q, 8);
            end
            5: q.push_back(KIND_NOP);
            6: begin
                // unhandled kinds, some of them wide enough to miss the mask
                if ($urandom_range(1)) k = 8'($urandom_range(16, 255));
                else k = 8'($urandom_range(6, 15));
                if (k == KIND_TS) k = k + 8'd1;
                len = $urandom_range(2, 6);
                q.push_back(k); q.push_back(8'(len)); add_random(q, len - 2);
            end
            default: begin
                q.push_back(KIND_EOL); add_random(q, $urandom_range(0, 3));
            end
        endcase
    endfunction

    function automatic t_bytes build_segment();
        t_bytes q;
        int s;
        int len;
        int keep;
        s = $urandom_range(99);
        if (s < 70) begin
            repeat ($urandom_range(1, 5)) add_option(q);
            if ($urandom_range(3) == 0) begin
                keep = $urandom_range(1, q.size());
                while (q.size() > keep) void'(q.pop_back());
            end
        end else if (s < 85) begin
            if ($urandom_range(1)) add_option(q);
            case ($urandom_range(3))
                0: begin
                    q.push_back(8'($urandom_range(2, 255))); q.push_back(8'($urandom_range(1)));
                end
                1: begin
                    len = 2 + 8 * $urandom_range(0, 4) + $urandom_range(1, 7);
                    q.push_back(KIND_SACK); q.push_back(8'(len)); add_random(q, len - 2);
                end
                2: begin
                    do len = $urandom_range(2, 20); while ((len - 2) % 4 == 0);
                    q.push_back(KIND_TS); q.push_back(8'(len)); add_random(q, len - 2);
                end
                default: begin
                    // legal timestamp sizes, body shorter than, as long as or longer than both words
                    len = 2 + 4 * $urandom_range(0, 4);
                    q.push_back(KIND_TS); q.push_back(8'(len)); add_random(q, len - 2);
                    add_option(q);
                end
            endcase
        end else begin
            add_random(q, $urandom_range(1, 12));
        end
        if (q.size() == 0) q.push_back(KIND_EOL);
        return q;
    endfunction

    initial begin
        t_bytes q;
        int r;
        bit paused;
        sb = new();
        paused = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        send_empty();
        q = '{KIND_MSS, 8'd4, 8'hFF, 8'hFF, KIND_WSCALE, 8'd3, 8'hFF};
        send_bytes(q, 1'b1);
        q = '{KIND_MSS};
        send_bytes(q, 1'b1);
        q = '{KIND_NOP, KIND_EOL, 8'h07};
        send_bytes(q, 1'b1);
        q = '{KIND_SACK, 8'd3};
        send_bytes(q, 1'b1);
        q = '{KIND_TS, 8'd5};
        send_bytes(q, 1'b1);
        q = '{KIND_SACK_OK, 8'd2, KIND_SACK_OK, 8'd2};
        send_bytes(q, 1'b1);
        q = '{KIND_WSCALE, 8'd1};
        send_bytes(q, 1'b1);
        q = '{KIND_TS, 8'd10, 8'hAA};
        send_bytes(q, 1'b1);
        q = '{KIND_MSS, 8'd4};
        send_bytes(q, 1'b0);
        send_empty();
        drain_results();

        items_sent = 0;
        while (items_sent < RANDOM_ITEMS) begin
            calm        = (items_sent >= 120 && items_sent < 200);
            in_idle_pct = calm ? 0 : IDLE_PCT;
            if (!paused && items_sent >= 250) begin
                paused = 1'b1;
                drain_results();
            end
            r = $urandom_range(99);
            if (r < 5) begin
                send_empty();
            end else if (r < 10) begin
                // segment cut short by an empty-area word
                send_bytes(build_segment(), 1'b0);
                send_empty();
            end else begin
                send_bytes(build_segment(), 1'b1);
            end
        end
        calm = 1'b0;
        drain_results();
        repeat (20) @(posedge clk);
        sb.leftover_check();
        if (sb.errors == 0) $display("== PASS ==");
        else $display("== FAIL ==");
        $finish;
    end

endmodule
